/* src/mex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mex_pkg - shared types and codes for the MIPS execute stage
// Opcodes, function codes, action codes and controller/datapath commands.
// ----------------------------------------------------------------------------
package mex_pkg;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [2:0] ACT_REG   = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_STORE = 3'd2;
  localparam logic [2:0] ACT_HALT  = 3'd3;
  localparam logic [2:0] ACT_NONE  = 3'd4;

  localparam int unsigned MUL_STEPS = 4;   // 16x16 partial products
  localparam int unsigned DIV_STEPS = 32;  // one quotient bit per step

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } mex_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the beat and run the ALU, shift and move ops
    logic mul_step;  // accumulate one partial product
    logic div_step;  // one restoring divide step
    logic fix;       // sign fixup, write HI/LO
    logic emit;      // strobe the result
    logic [4:0] step;
  } mex_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
  } mex_sts_t;

endpackage

/* src/mex_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mex_datapath - decode, ALU, HI/LO and shared multiply/divide unit
// Multiply by four 16x16 partial products; divide one bit per cycle.
// ----------------------------------------------------------------------------
module mex_datapath import mex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mex_cmd_t    cmd,
  output mex_sts_t    sts,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result,
  output logic [4:0]  out_dest_reg,
  output logic [2:0]  out_action,
  output logic [1:0]  out_access_size,
  output logic [31:0] out_store_data
);

  logic [31:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [31:0] res_r, res_nxt, sdata_r, sdata_nxt;
  logic [4:0]  dst_r, dst_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [1:0]  size_r, size_nxt;
  logic        valid_r;
  logic        is_mul_r, is_mul_nxt, is_div_r, is_div_nxt;
  logic        nega_r, nega_nxt, negq_r, negq_nxt;
  logic        bzero_r, bzero_nxt;
  logic [31:0] ma_r, ma_nxt, mb_r, mb_nxt, a_r, a_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;

  logic [5:0]  op, fn;
  logic [4:0]  sh;
  logic [31:0] simm, zimm, a, b, ma, mb;
  logic        na, nb;
  logic [15:0] pa, pb;
  logic [31:0] pp;
  logic [63:0] pps;
  logic [32:0] trial, sub;
  logic [63:0] prod;
  logic [31:0] q, r;

  assign op   = in_instruction[31:26];
  assign fn   = in_instruction[5:0];
  assign sh   = in_instruction[10:6];
  assign a    = in_operand_a;
  assign b    = in_operand_b;
  assign simm = {{16{in_instruction[15]}}, in_instruction[15:0]};
  assign zimm = {16'h0000, in_instruction[15:0]};
  assign na   = (fn == FN_MULT || fn == FN_DIV) && a[31];
  assign nb   = (fn == FN_MULT || fn == FN_DIV) && b[31];
  assign ma   = na ? (32'd0 - a) : a;
  assign mb   = nb ? (32'd0 - b) : b;

  // partial product select: step 0..3 -> (lo,lo),(lo,hi),(hi,lo),(hi,hi)
  assign pa  = cmd.step[1] ? ma_r[31:16] : ma_r[15:0];
  assign pb  = cmd.step[0] ? mb_r[31:16] : mb_r[15:0];
  assign pp  = pa * pb;
  assign pps = {32'd0, pp} << {{1'b0, cmd.step[1]} + {1'b0, cmd.step[0]}, 4'b0000};

  assign trial = {rem_r[31:0], ma_r[5'd31 - cmd.step]};
  assign sub   = trial - {1'b0, mb_r};

  assign prod = negq_r ? (64'd0 - acc_r) : acc_r;
  assign q    = negq_r ? (32'd0 - quo_r) : quo_r;
  assign r    = nega_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];

  always_comb begin
    hi_nxt = hi_r; lo_nxt = lo_r;
    res_nxt = res_r; sdata_nxt = sdata_r; dst_nxt = dst_r;
    act_nxt = act_r; size_nxt = size_r;
    is_mul_nxt = is_mul_r; is_div_nxt = is_div_r;
    nega_nxt = nega_r; negq_nxt = negq_r; bzero_nxt = bzero_r;
    ma_nxt = ma_r; mb_nxt = mb_r; a_nxt = a_r;
    acc_nxt = acc_r; rem_nxt = rem_r; quo_nxt = quo_r;
    if (cmd.load) begin
      res_nxt = 32'd0; dst_nxt = 5'd0; act_nxt = ACT_NONE;
      size_nxt = 2'd0; sdata_nxt = 32'd0;
      is_mul_nxt = 1'b0; is_div_nxt = 1'b0;
      nega_nxt = na; negq_nxt = na ^ nb; bzero_nxt = (b == 32'd0);
      ma_nxt = ma; mb_nxt = mb; a_nxt = a;
      acc_nxt = 64'd0; rem_nxt = 33'd0; quo_nxt = 32'd0;
      if (op == OP_RTYPE) begin
        act_nxt = ACT_REG;
        dst_nxt = in_instruction[15:11];
        case (fn)
          FN_ADD, FN_ADDU: res_nxt = a + b;
          FN_SUB, FN_SUBU: res_nxt = a - b;
          FN_AND:  res_nxt = a & b;
          FN_OR:   res_nxt = a | b;
          FN_XOR:  res_nxt = a ^ b;
          FN_NOR:  res_nxt = ~(a | b);
          FN_SLT:  res_nxt = {31'd0, $signed(a) < $signed(b)};
          FN_SLL:  res_nxt = b << sh;
          FN_SRL:  res_nxt = b >> sh;
          FN_SRA:  res_nxt = $unsigned($signed(b) >>> sh);
          FN_MFHI: res_nxt = hi_r;
          FN_MFLO: res_nxt = lo_r;
          FN_SYSCALL: begin act_nxt = ACT_HALT; dst_nxt = 5'd0; end
          FN_MTHI: begin hi_nxt = a; act_nxt = ACT_NONE; dst_nxt = 5'd0; end
          FN_MTLO: begin lo_nxt = a; act_nxt = ACT_NONE; dst_nxt = 5'd0; end
          FN_MULT, FN_MULTU: begin
            is_mul_nxt = 1'b1; act_nxt = ACT_NONE; dst_nxt = 5'd0;
          end
          FN_DIV, FN_DIVU: begin
            is_div_nxt = 1'b1; act_nxt = ACT_NONE; dst_nxt = 5'd0;
          end
          default: begin act_nxt = ACT_NONE; dst_nxt = 5'd0; end
        endcase
      end else begin
        case (op)
          OP_ADDI, OP_ADDIU: begin res_nxt = a + simm; act_nxt = ACT_REG; end
          OP_ANDI: begin res_nxt = a & zimm; act_nxt = ACT_REG; end
          OP_ORI:  begin res_nxt = a | zimm; act_nxt = ACT_REG; end
          OP_XORI: begin res_nxt = a ^ zimm; act_nxt = ACT_REG; end
          OP_LUI:  begin res_nxt = zimm << 16; act_nxt = ACT_REG; end
          OP_LB: begin res_nxt = a + simm; act_nxt = ACT_LOAD; size_nxt = 2'd0; end
          OP_LH: begin res_nxt = a + simm; act_nxt = ACT_LOAD; size_nxt = 2'd1; end
          OP_LW: begin res_nxt = a + simm; act_nxt = ACT_LOAD; size_nxt = 2'd2; end
          OP_SB, OP_SH, OP_SW: begin
            res_nxt = a + simm; act_nxt = ACT_STORE; sdata_nxt = b;
            size_nxt = (op == OP_SB) ? 2'd0 : (op == OP_SH) ? 2'd1 : 2'd2;
          end
          default: ;
        endcase
        if (act_nxt == ACT_REG || act_nxt == ACT_LOAD)
          dst_nxt = in_instruction[20:16];
      end
    end
    if (cmd.mul_step) acc_nxt = acc_r + pps;
    if (cmd.div_step) begin
      if (!sub[32]) begin
        rem_nxt = sub;
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      if (is_mul_r) begin
        hi_nxt = prod[63:32]; lo_nxt = prod[31:0];
      end else if (bzero_r) begin
        hi_nxt = a_r; lo_nxt = 32'hFFFF_FFFF;
      end else begin
        hi_nxt = r; lo_nxt = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= 32'd0; lo_r <= 32'd0; valid_r <= 1'b0;
      is_mul_r <= 1'b0; is_div_r <= 1'b0;
    end else begin
      hi_r <= hi_nxt; lo_r <= lo_nxt; valid_r <= cmd.emit;
      is_mul_r <= is_mul_nxt; is_div_r <= is_div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt; sdata_r <= sdata_nxt; dst_r <= dst_nxt;
    act_r <= act_nxt; size_r <= size_nxt;
    nega_r <= nega_nxt; negq_r <= negq_nxt; bzero_r <= bzero_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; a_r <= a_nxt;
    acc_r <= acc_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
  end

  assign sts.is_mul = is_mul_r;
  assign sts.is_div = is_div_r;

  assign out_valid       = valid_r;
  assign out_result      = res_r;
  assign out_dest_reg    = dst_r;
  assign out_action      = act_r;
  assign out_access_size = size_r;
  assign out_store_data  = sdata_r;

`ifndef SYNTHESIS
  a_mul_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(is_mul_r && is_div_r)) else $error("mul and div both flagged");
  a_muldiv_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (is_mul_r || is_div_r)) |-> out_action == ACT_NONE)
    else $error("mul/div with writeback");
  a_store_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_STORE) |-> out_dest_reg == 5'd0)
    else $error("store with destination");
`endif

endmodule

/* src/mex_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mex_ctrl - sequencer for the execute stage
// Strobes the result, then runs any multiply or divide steps and the fixup.
// ----------------------------------------------------------------------------
module mex_ctrl import mex_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mex_sts_t sts,
  output mex_cmd_t cmd,
  output logic     busy
);

  mex_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: if (start) begin state_nxt = ST_DONE; cnt_nxt = 5'd0; end
      ST_DONE: begin
        if (sts.is_mul) state_nxt = ST_MUL;
        else if (sts.is_div) state_nxt = ST_DIV;
        else state_nxt = ST_IDLE;
        cnt_nxt = 5'd0;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_STEPS - 1)) state_nxt = ST_FIX;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = ST_FIX;
      end
      ST_FIX: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ST_DONE: result registers loaded and out_valid high; HI/LO finish afterward
  always_comb begin
    cmd = '0;
    cmd.step = cnt_r;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin busy = 1'b0; cmd.load = start; cmd.emit = start; end
      ST_MUL:  cmd.mul_step = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIX:  cmd.fix = 1'b1;
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("no busy after start");
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul_step, cmd.div_step, cmd.fix}))
    else $error("overlapping commands");
  a_fix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |=> !busy) else $error("fix not followed by idle");
`endif

endmodule

/* src/mips_execute_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_execute_stage - MIPS32 integer execute stage
// Controller sequences a datapath holding the ALU, HI/LO and mul/div unit.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | start & !busy      | in_instruction, in_operand_a, in_operand_b
//  out     | out_valid (strobe) | out_result, out_dest_reg, out_action,
//          |                    | out_access_size, out_store_data
//
// ALU, load/store and HI/LO move ops are loaded in ST_IDLE and end in ST_DONE.
// MULT/MULTU then run ST_MUL (four 16x16 partial products), DIV/DIVU run ST_DIV
// (one quotient bit per cycle through the shared divide step), then ST_FIX.
// The result strobes the cycle after acceptance; HI/LO settle before busy drops.
// Synchronous active-low reset clears HI, LO and the sequencer.
// The receiver cannot stall; out_valid lasts one cycle.
// ----------------------------------------------------------------------------
module mips_execute_stage import mex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result,
  output logic [4:0]  out_dest_reg,
  output logic [2:0]  out_action,
  output logic [1:0]  out_access_size,
  output logic [31:0] out_store_data
);

  mex_cmd_t cmd;
  mex_sts_t sts;

  mex_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mex_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_instruction  (in_instruction),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .out_dest_reg    (out_dest_reg),
    .out_action      (out_action),
    .out_access_size (out_access_size),
    .out_store_data  (out_store_data)
  );

endmodule
